// ===== src/cll_pkg.sv =====
`timescale 1ns / 1ps
package cll_pkg;
   localparam int CAP = 256;
   localparam int PTR_W = 8;
   localparam int CNT_W = 9;
   localparam int VAL_W = 32;

   localparam logic [3:0] OP_CLEAR = 4'd0;
   localparam logic [3:0] OP_FRONT = 4'd1;
   localparam logic [3:0] OP_BACK = 4'd2;
   localparam logic [3:0] OP_PREV = 4'd3;
   localparam logic [3:0] OP_NEXT = 4'd4;
   localparam logic [3:0] OP_PREPEND = 4'd5;
   localparam logic [3:0] OP_APPEND = 4'd6;
   localparam logic [3:0] OP_INS_BEFORE = 4'd7;
   localparam logic [3:0] OP_INS_AFTER = 4'd8;
   localparam logic [3:0] OP_DEL_FRONT = 4'd9;
   localparam logic [3:0] OP_DEL_BACK = 4'd10;
   localparam logic [3:0] OP_DEL_CURSOR = 4'd11;
   localparam logic [3:0] OP_READ = 4'd12;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_EMPTY = 2'd1,
      ST_NOCUR = 2'd2,
      ST_FULL = 2'd3
   } cll_status_type;

   typedef struct packed {
      logic [3:0] req_type;
      logic signed [VAL_W-1:0] value;
   } cll_req_type;

   typedef struct packed {
      cll_status_type status;
      logic [CNT_W-1:0] list_length;
      logic cursor_defined;
      logic [PTR_W-1:0] cursor_position;
      logic signed [VAL_W-1:0] front_value;
      logic signed [VAL_W-1:0] back_value;
      logic signed [VAL_W-1:0] cursor_value;
   } cll_rsp_type;

   typedef struct packed {
      logic nxt_re;
      logic [PTR_W-1:0] nxt_ra;
      logic prv_re;
      logic [PTR_W-1:0] prv_ra;
      logic val_re;
      logic [PTR_W-1:0] val_ra;
      logic nxt_we;
      logic [PTR_W-1:0] nxt_wa;
      logic [PTR_W-1:0] nxt_wd;
      logic prv_we;
      logic [PTR_W-1:0] prv_wa;
      logic [PTR_W-1:0] prv_wd;
      logic val_we;
      logic [PTR_W-1:0] val_wa;
      logic [VAL_W-1:0] val_wd;
   } cll_mem_req_type;
endpackage

// ===== src/cll_mem.sv =====
`timescale 1ns / 1ps
module cll_mem (
   input  logic clock,
   input  cll_pkg::cll_mem_req_type mreq,
   output logic [cll_pkg::PTR_W-1:0] nxt_rd,
   output logic [cll_pkg::PTR_W-1:0] prv_rd,
   output logic [cll_pkg::VAL_W-1:0] val_rd
);
   import cll_pkg::*;

   logic [PTR_W-1:0] nxt_mem [CAP];
   logic [PTR_W-1:0] prv_mem [CAP];
   logic [VAL_W-1:0] val_mem [CAP];
   logic [PTR_W-1:0] nxt_rd_ff;
   logic [PTR_W-1:0] prv_rd_ff;
   logic [VAL_W-1:0] val_rd_ff;

   always_ff @(posedge clock) begin
      if (mreq.nxt_we) begin
         nxt_mem[mreq.nxt_wa] <= mreq.nxt_wd;
      end
      if (mreq.nxt_re) begin
         nxt_rd_ff <= nxt_mem[mreq.nxt_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (mreq.prv_we) begin
         prv_mem[mreq.prv_wa] <= mreq.prv_wd;
      end
      if (mreq.prv_re) begin
         prv_rd_ff <= prv_mem[mreq.prv_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (mreq.val_we) begin
         val_mem[mreq.val_wa] <= mreq.val_wd;
      end
      if (mreq.val_re) begin
         val_rd_ff <= val_mem[mreq.val_ra];
      end
   end

   assign nxt_rd = nxt_rd_ff;
   assign prv_rd = prv_rd_ff;
   assign val_rd = val_rd_ff;
endmodule

// ===== src/cursor_linked_list_engine_core.sv =====
`timescale 1ns / 1ps
// Doubly linked list of signed 32-bit values with one cursor, held in a pool
// of 256 nodes in three synchronous memories (values, next links, prev links).
// A request beat is taken on a rising edge where start is high and busy is low.
// busy stays high from that edge until the response has been shown.
// Each request runs a fixed sequence: read the links of the node it works on,
// read the value of the node that becomes front, back or cursor together with
// the free list successor, then link writes in S_WR1 and, where needed, S_WR2.
// The response beat is on rsp_data for exactly one cycle with rsp_strobe high,
// after the states S_RDLNK, S_RDVAL, S_WR1 and S_WR2; a new request can be taken
// the cycle after the strobe, so a request is finished before the next is taken.
// The receiver cannot stall, so every response must be taken when shown.
// Reset gives an empty list, an undefined cursor and an untouched node pool.
// No clearing pass is needed: nodes come from the free list, or else in order
// from a watermark, and only nodes on the list or the free list are used.
module cursor_linked_list_engine_core (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  cll_pkg::cll_req_type req_data,
   output logic rsp_strobe,
   output cll_pkg::cll_rsp_type rsp_data
);
   import cll_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_RDLNK = 6'b000010,
      S_RDVAL = 6'b000100,
      S_WR1 = 6'b001000,
      S_WR2 = 6'b010000,
      S_OUT = 6'b100000
   } cll_state_type;

   cll_state_type state_ff, state_in;
   logic [3:0] op_ff;
   logic [VAL_W-1:0] v_ff;
   logic [PTR_W-1:0] head_ff, tail_ff, cptr_ff, cidx_ff, fhead_ff;
   logic cv_ff;
   logic [CNT_W-1:0] cnt_ff, fcnt_ff, wm_ff;
   logic [VAL_W-1:0] fval_ff, bval_ff, cval_ff;
   cll_status_type st_ff, st_in;
   logic [PTR_W-1:0] la_next_ff, node_ff;
   logic mid_ff;

   cll_mem_req_type mreq;
   logic [PTR_W-1:0] nxt_rd, prv_rd;
   logic [VAL_W-1:0] val_rd;

   logic empty, room, at_front, at_back, ok, mid;
   logic front_rm, back_rm;
   logic [PTR_W-1:0] new_node, del_node;

   cll_mem u_mem (
      .clock (clock),
      .mreq  (mreq),
      .nxt_rd(nxt_rd),
      .prv_rd(prv_rd),
      .val_rd(val_rd)
   );

   assign empty = (cnt_ff == '0);
   assign room = (fcnt_ff != '0) || (wm_ff < CNT_W'(CAP));
   assign at_front = (cidx_ff == '0);
   assign at_back = ({1'b0, cidx_ff} + CNT_W'(1)) >= cnt_ff;
   assign new_node = (fcnt_ff != '0) ? fhead_ff : wm_ff[PTR_W-1:0];

   always_comb begin
      st_in = ST_OK;
      case (op_ff)
         OP_FRONT, OP_BACK, OP_DEL_FRONT, OP_DEL_BACK: begin
            if (empty) st_in = ST_EMPTY;
         end
         OP_PREV, OP_NEXT: begin
            if (!cv_ff) st_in = ST_NOCUR;
         end
         OP_PREPEND, OP_APPEND: begin
            if (!room) st_in = ST_FULL;
         end
         OP_INS_BEFORE, OP_INS_AFTER: begin
            if (empty) st_in = ST_EMPTY;
            else if (!cv_ff) st_in = ST_NOCUR;
            else if (!room) st_in = ST_FULL;
         end
         OP_DEL_CURSOR: begin
            if (empty) st_in = ST_EMPTY;
            else if (!cv_ff) st_in = ST_NOCUR;
         end
         default: st_in = ST_OK;
      endcase
   end

   assign ok = (st_in == ST_OK);
   assign mid = ((op_ff == OP_INS_BEFORE) && !at_front) ||
                ((op_ff == OP_INS_AFTER) && !at_back) ||
                ((op_ff == OP_DEL_CURSOR) && !at_front && !at_back);
   assign front_rm = (op_ff == OP_DEL_FRONT) || ((op_ff == OP_DEL_CURSOR) && at_front);
   assign back_rm = (op_ff == OP_DEL_BACK) ||
                    ((op_ff == OP_DEL_CURSOR) && at_back && !at_front);
   assign del_node = (op_ff == OP_DEL_FRONT) ? head_ff :
                     (op_ff == OP_DEL_BACK) ? tail_ff : cptr_ff;

   always_comb begin
      mreq = '0;
      case (state_ff)
         S_RDLNK: begin
            mreq.nxt_re = 1'b1;
            mreq.prv_re = 1'b1;
            mreq.nxt_ra = (op_ff == OP_DEL_FRONT) ? head_ff :
                          (op_ff == OP_DEL_BACK) ? tail_ff : cptr_ff;
            mreq.prv_ra = mreq.nxt_ra;
         end
         S_RDVAL: begin
            mreq.nxt_re = 1'b1;
            mreq.nxt_ra = fhead_ff;
            mreq.val_re = 1'b1;
            mreq.val_ra = ((op_ff == OP_PREV) || (op_ff == OP_DEL_BACK) ||
                           ((op_ff == OP_DEL_CURSOR) && !at_front)) ? prv_rd : nxt_rd;
         end
         S_WR1: begin
            if (ok) begin
               case (op_ff)
                  OP_PREPEND, OP_APPEND, OP_INS_BEFORE, OP_INS_AFTER: begin
                     mreq.val_we = 1'b1;
                     mreq.val_wa = node_ff;
                     mreq.val_wd = v_ff;
                     if (((op_ff == OP_PREPEND) && !empty) ||
                         ((op_ff == OP_INS_BEFORE) && at_front)) begin
                        mreq.nxt_we = 1'b1;
                        mreq.nxt_wa = node_ff;
                        mreq.nxt_wd = head_ff;
                        mreq.prv_we = 1'b1;
                        mreq.prv_wa = head_ff;
                        mreq.prv_wd = node_ff;
                     end else if (((op_ff == OP_APPEND) && !empty) ||
                                  ((op_ff == OP_INS_AFTER) && at_back)) begin
                        mreq.prv_we = 1'b1;
                        mreq.prv_wa = node_ff;
                        mreq.prv_wd = tail_ff;
                        mreq.nxt_we = 1'b1;
                        mreq.nxt_wa = tail_ff;
                        mreq.nxt_wd = node_ff;
                     end else if (op_ff == OP_INS_BEFORE) begin
                        mreq.nxt_we = 1'b1;
                        mreq.nxt_wa = node_ff;
                        mreq.nxt_wd = cptr_ff;
                        mreq.prv_we = 1'b1;
                        mreq.prv_wa = node_ff;
                        mreq.prv_wd = prv_rd;
                     end else if (op_ff == OP_INS_AFTER) begin
                        mreq.prv_we = 1'b1;
                        mreq.prv_wa = node_ff;
                        mreq.prv_wd = cptr_ff;
                        mreq.nxt_we = 1'b1;
                        mreq.nxt_wa = node_ff;
                        mreq.nxt_wd = la_next_ff;
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_CURSOR: begin
                     mreq.nxt_we = 1'b1;
                     mreq.nxt_wa = del_node;
                     mreq.nxt_wd = fhead_ff;
                     if (mid) begin
                        mreq.prv_we = 1'b1;
                        mreq.prv_wa = la_next_ff;
                        mreq.prv_wd = prv_rd;
                     end
                  end
                  OP_CLEAR: begin
                     mreq.nxt_we = !empty;
                     mreq.nxt_wa = tail_ff;
                     mreq.nxt_wd = fhead_ff;
                  end
                  default: mreq.nxt_we = 1'b0;
               endcase
            end
         end
         S_WR2: begin
            if (mid_ff) begin
               case (op_ff)
                  OP_INS_BEFORE: begin
                     mreq.nxt_we = 1'b1;
                     mreq.nxt_wa = prv_rd;
                     mreq.nxt_wd = node_ff;
                     mreq.prv_we = 1'b1;
                     mreq.prv_wa = cptr_ff;
                     mreq.prv_wd = node_ff;
                  end
                  OP_INS_AFTER: begin
                     mreq.prv_we = 1'b1;
                     mreq.prv_wa = la_next_ff;
                     mreq.prv_wd = node_ff;
                     mreq.nxt_we = 1'b1;
                     mreq.nxt_wa = cptr_ff;
                     mreq.nxt_wd = node_ff;
                  end
                  OP_DEL_CURSOR: begin
                     mreq.nxt_we = 1'b1;
                     mreq.nxt_wa = prv_rd;
                     mreq.nxt_wd = la_next_ff;
                  end
                  default: mreq.nxt_we = 1'b0;
               endcase
            end
         end
         default: mreq = '0;
      endcase
   end

   always_comb begin
      case (state_ff)
         S_IDLE: state_in = start ? S_RDLNK : S_IDLE;
         S_RDLNK: state_in = S_RDVAL;
         S_RDVAL: state_in = S_WR1;
         S_WR1: state_in = S_WR2;
         S_WR2: state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && start) begin
         op_ff <= req_data.req_type;
         v_ff <= req_data.value;
      end
      if (state_ff == S_RDVAL) begin
         la_next_ff <= nxt_rd;
         node_ff <= new_node;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cptr_ff <= '0;
         cidx_ff <= '0;
         cv_ff <= 1'b0;
         cnt_ff <= '0;
         fhead_ff <= '0;
         fcnt_ff <= '0;
         wm_ff <= '0;
         st_ff <= ST_OK;
         mid_ff <= 1'b0;
         fval_ff <= '0;
         bval_ff <= '0;
         cval_ff <= '0;
      end else if (state_ff == S_WR1) begin
         st_ff <= st_in;
         mid_ff <= ok && mid;
         if (ok) begin
            case (op_ff)
               OP_CLEAR: begin
                  if (!empty) begin
                     fhead_ff <= head_ff;
                     fcnt_ff <= fcnt_ff + cnt_ff;
                  end
                  cnt_ff <= '0;
                  head_ff <= '0;
                  tail_ff <= '0;
                  cv_ff <= 1'b0;
                  cptr_ff <= '0;
                  cidx_ff <= '0;
               end
               OP_FRONT: begin
                  cv_ff <= 1'b1;
                  cptr_ff <= head_ff;
                  cidx_ff <= '0;
                  cval_ff <= fval_ff;
               end
               OP_BACK: begin
                  cv_ff <= 1'b1;
                  cptr_ff <= tail_ff;
                  cidx_ff <= PTR_W'(cnt_ff - CNT_W'(1));
                  cval_ff <= bval_ff;
               end
               OP_PREV: begin
                  if (at_front) begin
                     cv_ff <= 1'b0;
                     cptr_ff <= '0;
                     cidx_ff <= '0;
                  end else begin
                     cptr_ff <= prv_rd;
                     cidx_ff <= cidx_ff - PTR_W'(1);
                     cval_ff <= val_rd;
                  end
               end
               OP_NEXT: begin
                  if (at_back) begin
                     cv_ff <= 1'b0;
                     cptr_ff <= '0;
                     cidx_ff <= '0;
                  end else begin
                     cptr_ff <= la_next_ff;
                     cidx_ff <= cidx_ff + PTR_W'(1);
                     cval_ff <= val_rd;
                  end
               end
               OP_PREPEND, OP_APPEND, OP_INS_BEFORE, OP_INS_AFTER: begin
                  if (fcnt_ff != '0) begin
                     fhead_ff <= nxt_rd;
                     fcnt_ff <= fcnt_ff - CNT_W'(1);
                  end else begin
                     wm_ff <= wm_ff + CNT_W'(1);
                  end
                  cnt_ff <= cnt_ff + CNT_W'(1);
                  if ((op_ff == OP_PREPEND) || ((op_ff == OP_INS_BEFORE) && at_front)) begin
                     head_ff <= node_ff;
                     fval_ff <= v_ff;
                     if (empty) begin
                        tail_ff <= node_ff;
                        bval_ff <= v_ff;
                     end else if (cv_ff) begin
                        cidx_ff <= cidx_ff + PTR_W'(1);
                     end
                  end else if ((op_ff == OP_APPEND) ||
                               ((op_ff == OP_INS_AFTER) && at_back)) begin
                     tail_ff <= node_ff;
                     bval_ff <= v_ff;
                     if (empty) begin
                        head_ff <= node_ff;
                        fval_ff <= v_ff;
                     end
                  end else if (op_ff == OP_INS_BEFORE) begin
                     cidx_ff <= cidx_ff + PTR_W'(1);
                  end
               end
               OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_CURSOR: begin
                  fhead_ff <= del_node;
                  fcnt_ff <= fcnt_ff + CNT_W'(1);
                  cnt_ff <= cnt_ff - CNT_W'(1);
                  if (front_rm) begin
                     if (cnt_ff == CNT_W'(1)) begin
                        head_ff <= '0;
                        tail_ff <= '0;
                     end else begin
                        head_ff <= la_next_ff;
                        fval_ff <= val_rd;
                     end
                     if (cv_ff && !at_front) begin
                        cidx_ff <= cidx_ff - PTR_W'(1);
                     end
                  end else if (back_rm) begin
                     if (cnt_ff == CNT_W'(1)) begin
                        head_ff <= '0;
                        tail_ff <= '0;
                     end else begin
                        tail_ff <= prv_rd;
                        bval_ff <= val_rd;
                     end
                  end
                  if ((op_ff == OP_DEL_CURSOR) ||
                      (front_rm && at_front) ||
                      (back_rm && (({1'b0, cidx_ff} + CNT_W'(1)) == cnt_ff))) begin
                     if ((op_ff == OP_DEL_CURSOR) || cv_ff) begin
                        cv_ff <= 1'b0;
                        cptr_ff <= '0;
                        cidx_ff <= '0;
                     end
                  end
               end
               default: cv_ff <= cv_ff;
            endcase
         end
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_OUT);

   always_comb begin
      rsp_data.status = st_ff;
      rsp_data.list_length = cnt_ff;
      rsp_data.cursor_defined = cv_ff;
      rsp_data.cursor_position = cv_ff ? cidx_ff : '0;
      rsp_data.front_value = empty ? '0 : fval_ff;
      rsp_data.back_value = empty ? '0 : bval_ff;
      rsp_data.cursor_value = cv_ff ? cval_ff : '0;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAP))
      else $error("list length beyond pool size");

   a_pool_balance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((fcnt_ff + cnt_ff) == wm_ff))
      else $error("free and used nodes do not add up to the watermark");

   a_cursor_in_list: assert property (@(posedge clock) disable iff (reset)
      cv_ff |-> ({1'b0, cidx_ff} < cnt_ff))
      else $error("cursor index outside the list");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response held for more than one cycle");
endmodule
